@@ rtl/stack_machine_executor_assert.svh @@
// ----------------------------------------------------------------------------
// stack machine executor assertion macros
// concurrent check helpers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTOR_ASSERT_SVH
`define STACK_MACHINE_EXECUTOR_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define SME_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sme assertion failed");
// next-cycle implication
`define SME_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sme assertion failed");
`else
`define SME_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define SME_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

@@ rtl/sme_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sme_pkg
// opcodes, result codes and controller/datapath link types
// ----------------------------------------------------------------------------
package sme_pkg;

   localparam logic [3:0] OP_ADD    = 4'd0;
   localparam logic [3:0] OP_SUB    = 4'd1;
   localparam logic [3:0] OP_MUL    = 4'd2;
   localparam logic [3:0] OP_DIV    = 4'd3;
   localparam logic [3:0] OP_POP    = 4'd4;
   localparam logic [3:0] OP_PUSH   = 4'd5;
   localparam logic [3:0] OP_DUP    = 4'd6;
   localparam logic [3:0] OP_SWAP   = 4'd7;
   localparam logic [3:0] OP_PRINT  = 4'd8;
   localparam logic [3:0] OP_PRINTC = 4'd9;
   localparam logic [3:0] OP_INC    = 4'd10;
   localparam logic [3:0] OP_DEC    = 4'd11;
   localparam logic [3:0] OP_CALL   = 4'd12;
   localparam logic [3:0] OP_RET    = 4'd13;
   localparam logic [3:0] OP_NOP    = 4'd14;
   localparam logic [3:0] OP_HALT   = 4'd15;

   localparam logic [2:0] ERR_OK      = 3'd0;
   localparam logic [2:0] ERR_DUNDER  = 3'd1;
   localparam logic [2:0] ERR_DOVER   = 3'd2;
   localparam logic [2:0] ERR_DIVZERO = 3'd3;
   localparam logic [2:0] ERR_RUNDER  = 3'd4;
   localparam logic [2:0] ERR_ROVER   = 3'd5;

   localparam logic [1:0] KIND_NONE     = 2'd0;
   localparam logic [1:0] KIND_NUMBER   = 2'd1;
   localparam logic [1:0] KIND_CHAR     = 2'd2;
   localparam logic [1:0] KIND_NONASCII = 2'd3;

   localparam logic [7:0] ASCII_MAX = 8'd127;

   typedef struct packed {
      logic take;
      logic rd_second;
      logic cap_a;
      logic exec;
      logic div_step;
      logic div_wb;
      logic swap_wb;
      logic load_rsp;
   } sme_cmd_type;

   typedef struct packed {
      logic div_go;
      logic swap_go;
      logic div_done;
      logic halted;
   } sme_status_type;

endpackage

@@ rtl/sme_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sme channel interfaces
// instruction channel and result channel, valid/ready
// ----------------------------------------------------------------------------
interface sme_req_if;
   logic               valid;
   logic               ready;
   logic [3:0]         command;
   logic signed [31:0] operand;

   modport source (output valid, command, operand, input ready);
   modport sink   (input valid, command, operand, output ready);
endinterface

interface sme_rsp_if;
   logic               valid;
   logic               ready;
   logic [15:0]        next_pc;
   logic [1:0]         print_kind;
   logic signed [31:0] print_value;
   logic               halted;
   logic [2:0]         error_code;

   modport source (output valid, next_pc, print_kind, print_value, halted, error_code,
                   input ready);
   modport sink   (input valid, next_pc, print_kind, print_value, halted, error_code,
                   output ready);
endinterface

@@ rtl/stack_machine_executor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_executor
// executes one stack-machine instruction per item, one result item each
// ----------------------------------------------------------------------------
// usage
//   req channel: one item per instruction, command opcode plus the code word
//   that follows it (push value or call target)
//   rsp channel: one item per instruction with next pc, print output,
//   halted flag and error code
//   an instruction is accepted, its top and second data stack entries are
//   read in turn through the single read port of the data stack memory,
//   it executes, swap adds a second data stack write, div runs the serial
//   divider, and the result goes to the output register; a new
//   instruction is accepted only once the previous result is loaded
//   reset clears the stack counts, pc and halted flag; stack contents
//   are not cleared, and an entry is never used before being written
//   a stalled rsp holds its item in the output register; the next
//   instruction is still accepted and executed, and waits in a staging
//   register until the output register frees
// ----------------------------------------------------------------------------
`include "stack_machine_executor_assert.svh"

module stack_machine_executor import sme_pkg::*; #(
   parameter int DATA_DEPTH   = 64,
   parameter int RETURN_DEPTH = 16,
   parameter int PC_WIDTH     = 16
) (
   input logic       clock,
   input logic       reset,
   sme_req_if.sink   req,
   sme_rsp_if.source rsp
);

   sme_cmd_type    cmd;
   sme_status_type status;

   // sequencer
   sme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // stacks, alu, divider and result registers
   sme_datapath #(
      .DATA_DEPTH   (DATA_DEPTH),
      .RETURN_DEPTH (RETURN_DEPTH),
      .PC_WIDTH     (PC_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_command     (req.command),
      .req_operand     (req.operand),
      .rsp_next_pc     (rsp.next_pc),
      .rsp_print_kind  (rsp.print_kind),
      .rsp_print_value (rsp.print_value),
      .rsp_halted      (rsp.halted),
      .rsp_error_code  (rsp.error_code)
   );

   // a faulted instruction prints nothing
   `SME_ASSERT_IMPLY(a_err_no_print, clock, reset, rsp.valid && rsp.error_code != ERR_OK, rsp.print_kind == KIND_NONE)
   // a halted machine reports neither error nor print
   `SME_ASSERT_IMPLY(a_halt_quiet, clock, reset, rsp.valid && rsp.halted, rsp.error_code == ERR_OK && rsp.print_kind == KIND_NONE)
   // halt is sticky until reset
   `SME_ASSERT_NEXT(a_halt_sticky, clock, reset, status.halted, status.halted)

endmodule

@@ rtl/sme_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sme_datapath
// stacks, program counter, alu, serial divider and result registers
// ----------------------------------------------------------------------------
module sme_datapath import sme_pkg::*; #(
   parameter int DATA_DEPTH   = 64,
   parameter int RETURN_DEPTH = 16,
   parameter int PC_WIDTH     = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  sme_cmd_type        cmd,
   output sme_status_type     status,
   input  logic [3:0]         req_command,
   input  logic signed [31:0] req_operand,
   output logic [15:0]        rsp_next_pc,
   output logic [1:0]         rsp_print_kind,
   output logic signed [31:0] rsp_print_value,
   output logic               rsp_halted,
   output logic [2:0]         rsp_error_code
);

   localparam int DAW = $clog2(DATA_DEPTH);
   localparam int DCW = $clog2(DATA_DEPTH + 1);
   localparam int RAW = (RETURN_DEPTH > 1) ? $clog2(RETURN_DEPTH) : 1;
   localparam int RCW = $clog2(RETURN_DEPTH + 1);

   logic [31:0]         dmem [DATA_DEPTH];
   logic [PC_WIDTH-1:0] rmem [RETURN_DEPTH];

   logic [3:0]          op_ff;
   logic [31:0]         opnd_ff;
   logic [31:0]         a_ff;
   logic [31:0]         rd_ff;
   logic [PC_WIDTH-1:0] rs_rd_ff;
   logic [DCW-1:0]      dcnt_ff;
   logic [RCW-1:0]      rcnt_ff;
   logic [PC_WIDTH-1:0] pc_ff;
   logic                halt_ff;

   logic [31:0]         dq_ff;
   logic [31:0]         rem_ff;
   logic [31:0]         dvs_ff;
   logic [5:0]          step_ff;
   logic                qneg_ff;

   logic [PC_WIDTH-1:0] res_npc_ff;
   logic [1:0]          res_kind_ff;
   logic [31:0]         res_pval_ff;
   logic                res_halt_ff;
   logic [2:0]          res_err_ff;

   logic [15:0]         out_npc_ff;
   logic [1:0]          out_kind_ff;
   logic [31:0]         out_pval_ff;
   logic                out_halt_ff;
   logic [2:0]          out_err_ff;

   logic [DCW-1:0]      dm1, dm2, dp1;
   logic [RCW-1:0]      rm1;
   logic [PC_WIDTH-1:0] pc1, pc2;
   logic                under1, under2, full, rfull, rempty;

   logic [2:0]          err;
   logic [1:0]          kind;
   logic [31:0]         pval;
   logic [PC_WIDTH-1:0] npc;
   logic [DCW-1:0]      ncnt;
   logic [RCW-1:0]      nrcnt;
   logic                nhalt;
   logic                wen;
   logic [DAW-1:0]      waddr;
   logic [31:0]         wdata;
   logic                rs_wen;
   logic                div_go;
   logic                swap_go;

   logic                mem_we;
   logic [DAW-1:0]      mem_wa;
   logic [31:0]         mem_wd;
   logic [DAW-1:0]      mem_ra;

   logic [32:0]         rem_sh;
   logic [33:0]         diff;
   logic                ge;
   logic [31:0]         quot;

   assign dm1    = dcnt_ff - DCW'(1);
   assign dm2    = dcnt_ff - DCW'(2);
   assign dp1    = dcnt_ff + DCW'(1);
   assign rm1    = rcnt_ff - RCW'(1);
   assign pc1    = pc_ff + PC_WIDTH'(1);
   assign pc2    = pc_ff + PC_WIDTH'(2);
   assign under1 = (dcnt_ff == '0);
   assign under2 = (dcnt_ff < DCW'(2));
   assign full   = (dcnt_ff == DCW'(DATA_DEPTH));
   assign rfull  = (rcnt_ff == RCW'(RETURN_DEPTH));
   assign rempty = (rcnt_ff == '0);

   // instruction decode and stack effects, a_ff is top, rd_ff the entry below
   always_comb begin
      err     = ERR_OK;
      kind    = KIND_NONE;
      pval    = '0;
      npc     = pc_ff;
      ncnt    = dcnt_ff;
      nrcnt   = rcnt_ff;
      nhalt   = halt_ff;
      wen     = 1'b0;
      waddr   = dm1[DAW-1:0];
      wdata   = '0;
      rs_wen  = 1'b0;
      div_go  = 1'b0;
      swap_go = 1'b0;
      if (!halt_ff) begin
         npc = pc1;
         unique case (op_ff) inside
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
               if (under2) begin
                  err = ERR_DUNDER;
               end else if (op_ff == OP_DIV && a_ff == '0) begin
                  err = ERR_DIVZERO;
               end else begin
                  ncnt   = dm1;
                  waddr  = dm2[DAW-1:0];
                  wen    = (op_ff != OP_DIV);
                  div_go = (op_ff == OP_DIV);
                  case (op_ff)
                     OP_ADD:  wdata = rd_ff + a_ff;
                     OP_SUB:  wdata = rd_ff - a_ff;
                     default: wdata = rd_ff * a_ff;
                  endcase
               end
            end
            OP_POP: begin
               if (under1) err = ERR_DUNDER;
               else ncnt = dm1;
            end
            OP_PUSH: begin
               if (full) begin
                  err = ERR_DOVER;
               end else begin
                  wen   = 1'b1;
                  waddr = dcnt_ff[DAW-1:0];
                  wdata = opnd_ff;
                  ncnt  = dp1;
                  npc   = pc2;
               end
            end
            OP_DUP: begin
               if (under1) begin
                  err = ERR_DUNDER;
               end else if (full) begin
                  err = ERR_DOVER;
               end else begin
                  wen   = 1'b1;
                  waddr = dcnt_ff[DAW-1:0];
                  wdata = a_ff;
                  ncnt  = dp1;
               end
            end
            OP_SWAP: begin
               if (under2) begin
                  err = ERR_DUNDER;
               end else begin
                  wen     = 1'b1;
                  wdata   = rd_ff;
                  swap_go = 1'b1;
               end
            end
            OP_PRINT, OP_PRINTC: begin
               if (under1) begin
                  err = ERR_DUNDER;
               end else begin
                  pval = a_ff;
                  if (op_ff == OP_PRINT) kind = KIND_NUMBER;
                  else if (a_ff[7:0] <= ASCII_MAX) kind = KIND_CHAR;
                  else kind = KIND_NONASCII;
               end
            end
            OP_INC, OP_DEC: begin
               if (under1) begin
                  err = ERR_DUNDER;
               end else begin
                  wen   = 1'b1;
                  wdata = (op_ff == OP_INC) ? a_ff + 32'd1 : a_ff - 32'd1;
               end
            end
            OP_CALL: begin
               if (rfull) begin
                  err = ERR_ROVER;
               end else begin
                  rs_wen = 1'b1;
                  nrcnt  = rcnt_ff + RCW'(1);
                  npc    = opnd_ff[PC_WIDTH-1:0];
               end
            end
            OP_RET: begin
               if (rempty) begin
                  err = ERR_RUNDER;
               end else begin
                  nrcnt = rm1;
                  npc   = rs_rd_ff;
               end
            end
            OP_NOP: begin
            end
            OP_HALT: begin
               nhalt = 1'b1;
               npc   = pc_ff;
            end
         endcase
         if (err != ERR_OK) npc = pc_ff;
      end
   end

   assign status.div_go   = div_go;
   assign status.swap_go  = swap_go;
   assign status.div_done = (step_ff == 6'd32);
   assign status.halted   = halt_ff;

   // serial restoring divider, one quotient bit per cycle
   assign rem_sh = {rem_ff, dq_ff[31]};
   assign diff   = {1'b0, rem_sh} - {2'b00, dvs_ff};
   assign ge     = !diff[33];
   assign quot   = qneg_ff ? (32'd0 - dq_ff) : dq_ff;

   always_ff @(posedge clock) begin
      if (cmd.exec && div_go) begin
         dq_ff   <= rd_ff[31] ? (32'd0 - rd_ff) : rd_ff;
         dvs_ff  <= a_ff[31] ? (32'd0 - a_ff) : a_ff;
         rem_ff  <= '0;
         step_ff <= '0;
         qneg_ff <= rd_ff[31] ^ a_ff[31];
      end else if (cmd.div_step) begin
         rem_ff  <= ge ? diff[31:0] : rem_sh[31:0];
         dq_ff   <= {dq_ff[30:0], ge};
         step_ff <= step_ff + 6'd1;
      end
   end

   // data stack memory, one write and one registered read per cycle
   always_comb begin
      mem_we = (cmd.exec && wen) || cmd.div_wb || cmd.swap_wb;
      mem_wa = waddr;
      mem_wd = wdata;
      if (cmd.div_wb) begin
         mem_wa = dm1[DAW-1:0];
         mem_wd = quot;
      end else if (cmd.swap_wb) begin
         mem_wa = dm2[DAW-1:0];
         mem_wd = a_ff;
      end
      mem_ra = cmd.rd_second ? dm2[DAW-1:0] : dm1[DAW-1:0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) dmem[mem_wa] <= mem_wd;
      rd_ff <= dmem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && rs_wen) rmem[rcnt_ff[RAW-1:0]] <= pc2;
      rs_rd_ff <= rmem[rm1[RAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
         rcnt_ff <= '0;
         pc_ff   <= '0;
         halt_ff <= 1'b0;
      end else if (cmd.exec) begin
         dcnt_ff <= ncnt;
         rcnt_ff <= nrcnt;
         pc_ff   <= npc;
         halt_ff <= nhalt;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         op_ff   <= req_command;
         opnd_ff <= req_operand;
      end
      if (cmd.cap_a) a_ff <= rd_ff;
      if (cmd.exec) begin
         res_npc_ff  <= npc;
         res_kind_ff <= kind;
         res_pval_ff <= pval;
         res_halt_ff <= nhalt;
         res_err_ff  <= err;
      end
      if (cmd.load_rsp) begin
         out_npc_ff  <= 16'(res_npc_ff);
         out_kind_ff <= res_kind_ff;
         out_pval_ff <= res_pval_ff;
         out_halt_ff <= res_halt_ff;
         out_err_ff  <= res_err_ff;
      end
   end

   assign rsp_next_pc     = out_npc_ff;
   assign rsp_print_kind  = out_kind_ff;
   assign rsp_print_value = out_pval_ff;
   assign rsp_halted      = out_halt_ff;
   assign rsp_error_code  = out_err_ff;

endmodule

@@ rtl/sme_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sme_ctrl
// sequencer: fetch stack operands, execute, divide or swap write-back, hand over result
// ----------------------------------------------------------------------------
module sme_ctrl import sme_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  sme_status_type status,
   output sme_cmd_type    cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RDB  = 3'd1;
   localparam logic [2:0] S_EXEC = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_SWAP = 3'd4;
   localparam logic [2:0] S_FIN  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_RDB;
            end
         end
         S_RDB: begin
            cmd.cap_a     = 1'b1;
            cmd.rd_second = 1'b1;
            state_in      = S_EXEC;
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            if (status.div_go) state_in = S_DIV;
            else if (status.swap_go) state_in = S_SWAP;
            else state_in = S_FIN;
         end
         S_DIV: begin
            if (status.div_done) begin
               cmd.div_wb = 1'b1;
               state_in   = S_FIN;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         S_SWAP: begin
            cmd.swap_wb = 1'b1;
            state_in    = S_FIN;
         end
         S_FIN: begin
            if (!valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.load_rsp) valid_in = 1'b1;
      else if (rsp_ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

endmodule
